[src/gpfm_pkg.sv]
`timescale 1ns / 1ps
// Package for the grid period frequency meter: shared constants, register
// indexes, controller states and the command/status/result structs.
// No dependencies.
package gpfm_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    // clock_hz * 100 fits in 39 bits (100 < 2^7)
    localparam int QUOT_W    = 39;
    localparam int DIV_CNT_W = $clog2(QUOT_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUOT_W - 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] CLOCK_HZ_RST = 32'd200000000;
    localparam logic [15:0] MIN_CENT_RST = 16'd4500;
    localparam logic [15:0] MAX_CENT_RST = 16'd7000;
    localparam logic [15:0] FREQ_SAT     = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLOCK_HZ = 2'd0,
        REG_MIN_CENT = 2'd1,
        REG_MAX_CENT = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic take;      // input item accepted this cycle
        logic div_load;  // accepted item is an evaluated edge: load divider
        logic div_step;  // one quotient bit
        logic div_done;  // quotient ready: update hold and emit result
    } ctrl_cmd_t;

    typedef struct packed {
        logic eval_edge; // pending input item needs a division
        logic div_last;  // divider on its final bit
    } dp_status_t;

    typedef struct packed {
        logic [15:0] freq_cent;
        logic [31:0] period_ticks;
        logic        cycle_boundary;
        logic        zero_cross;
        logic        freq_update;
    } result_t;

endpackage

[src/grid_period_frequency_meter.sv]
`timescale 1ns / 1ps
// Top level of the grid period frequency meter: controller, datapath and
// output buffer. Depends on gpfm_pkg, gpfm_ctrl, gpfm_dp, gpfm_outbuf.
//
//  channel  | handshake         | payload
//  ---------+-------------------+--------------------------------------------
//  input    | s_valid/s_ready   | s_signal_level
//  result   | m_valid/m_ready   | m_freq_cent, m_period_ticks, m_cycle_boundary,
//           |                   | m_zero_cross, m_freq_update
//  config   | cfg_wr_en         | cfg_addr, cfg_wdata
//
// One result per input item. For an item that is not an evaluated falling edge,
// the result is pushed when it is taken. An evaluated edge goes through load, the
// 39 restoring-divider quotient bits and finish; s_ready is low through finish.
// Reset is synchronous, active low; no clearing pass after reset.
// s_ready also drops while both the output register and skid entry are full.
module grid_period_frequency_meter #(
    parameter int COUNT_WIDTH = gpfm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [gpfm_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [gpfm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_signal_level,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [15:0]                     m_freq_cent,
    output logic [31:0]                     m_period_ticks,
    output logic                            m_cycle_boundary,
    output logic                            m_zero_cross,
    output logic                            m_freq_update
);

    gpfm_pkg::ctrl_cmd_t  cmd;
    gpfm_pkg::dp_status_t status;
    gpfm_pkg::result_t    res_data;
    gpfm_pkg::result_t    m_data;
    logic                 res_push;
    logic                 out_full;

    gpfm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_full (out_full),
        .status   (status),
        .cmd      (cmd)
    );

    gpfm_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .signal_level (s_signal_level),
        .cmd          (cmd),
        .status       (status),
        .res_push     (res_push),
        .res_data     (res_data)
    );

    gpfm_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .full      (out_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_freq_cent      = m_data.freq_cent;
    assign m_period_ticks   = m_data.period_ticks;
    assign m_cycle_boundary = m_data.cycle_boundary;
    assign m_zero_cross     = m_data.zero_cross;
    assign m_freq_update    = m_data.freq_update;

endmodule

[src/gpfm_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: input handshake and divider sequencing.
// Depends on gpfm_pkg.
module gpfm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                out_full,
    input  gpfm_pkg::dp_status_t status,
    output gpfm_pkg::ctrl_cmd_t  cmd
);

    gpfm_pkg::ctrl_state_t state_reg, state_next;
    logic take;

    assign s_ready = (state_reg == gpfm_pkg::ST_IDLE) && !out_full;
    assign take    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gpfm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gpfm_pkg::ST_IDLE: begin
                if (take && status.eval_edge) begin
                    state_next = gpfm_pkg::ST_DIVIDE;
                end
            end
            gpfm_pkg::ST_DIVIDE: begin
                if (status.div_last) begin
                    state_next = gpfm_pkg::ST_FINISH;
                end
            end
            gpfm_pkg::ST_FINISH: begin
                state_next = gpfm_pkg::ST_IDLE;
            end
            default: begin
                state_next = gpfm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            gpfm_pkg::ST_IDLE: begin
                cmd.take     = take;
                cmd.div_load = take && status.eval_edge;
            end
            gpfm_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            gpfm_pkg::ST_FINISH: begin
                cmd.div_done = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[src/gpfm_dp.sv]
`timescale 1ns / 1ps
// Datapath: configuration registers, tick counter, edge detect, restoring
// divider and range check. Depends on gpfm_pkg.
module gpfm_dp #(
    parameter int COUNT_WIDTH = gpfm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [gpfm_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [gpfm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                signal_level,
    input  gpfm_pkg::ctrl_cmd_t                 cmd,
    output gpfm_pkg::dp_status_t                status,
    output logic                                res_push,
    output gpfm_pkg::result_t                   res_data
);

    localparam int QW = gpfm_pkg::QUOT_W;

    logic [31:0] clock_hz_reg;
    logic [15:0] min_cent_reg;
    logic [15:0] max_cent_reg;

    logic                   prev_level_reg;
    logic                   primed_reg;
    logic [COUNT_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic [COUNT_WIDTH-1:0] period_reg;
    logic [15:0]            freq_hold_reg;

    logic [QW-1:0]                  dq_reg;
    logic [COUNT_WIDTH-1:0]         rem_reg;
    logic [gpfm_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic          fall;
    logic [QW-1:0] scaled;
    logic [COUNT_WIDTH:0] rem_sh;
    logic [COUNT_WIDTH:0] rem_diff;
    logic          rem_ge;
    logic          range_ok;
    logic [15:0]   freq_sat;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= gpfm_pkg::CLOCK_HZ_RST;
            min_cent_reg <= gpfm_pkg::MIN_CENT_RST;
            max_cent_reg <= gpfm_pkg::MAX_CENT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                gpfm_pkg::REG_CLOCK_HZ: clock_hz_reg <= cfg_wdata;
                gpfm_pkg::REG_MIN_CENT: min_cent_reg <= cfg_wdata[15:0];
                gpfm_pkg::REG_MAX_CENT: max_cent_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- edge detect and period ----------------
    assign tick_count_next = tick_count_reg + COUNT_WIDTH'(1);
    assign fall            = prev_level_reg && !signal_level;

    assign status.eval_edge = fall && primed_reg && (tick_count_next != '0);
    assign status.div_last  = (div_cnt_reg == gpfm_pkg::DIV_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= 1'b0;
            primed_reg     <= 1'b0;
            tick_count_reg <= '0;
            period_reg     <= '0;
            freq_hold_reg  <= '0;
        end else begin
            if (cmd.take) begin
                prev_level_reg <= signal_level;
                if (fall) begin
                    tick_count_reg <= '0;
                    primed_reg     <= 1'b1;
                    if (primed_reg) begin
                        period_reg <= tick_count_next;
                    end
                end else begin
                    tick_count_reg <= tick_count_next;
                end
            end
            if (cmd.div_done) begin
                freq_hold_reg <= range_ok ? freq_sat : 16'd0;
            end
        end
    end

    // ---------------- restoring divider: clock_hz*100 / period ----------------
    // x*100 = x*64 + x*32 + x*4
    assign scaled = (QW'(clock_hz_reg) << 6) + (QW'(clock_hz_reg) << 5)
                  + (QW'(clock_hz_reg) << 2);

    assign rem_sh   = {rem_reg, dq_reg[QW-1]};
    assign rem_diff = rem_sh - {1'b0, period_reg};
    assign rem_ge   = (rem_sh >= {1'b0, period_reg});

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            dq_reg      <= scaled;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            dq_reg      <= {dq_reg[QW-2:0], rem_ge};
            rem_reg     <= rem_ge ? rem_diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
            div_cnt_reg <= div_cnt_reg + gpfm_pkg::DIV_CNT_W'(1);
        end
    end

    // min <= scaled/period  <=>  q >= min
    // scaled <= period*max  <=>  q < max, or q == max with no remainder
    assign range_ok = (dq_reg >= QW'(min_cent_reg))
                   && ((dq_reg < QW'(max_cent_reg))
                       || ((dq_reg == QW'(max_cent_reg)) && (rem_reg == '0)));
    assign freq_sat = (dq_reg > QW'(gpfm_pkg::FREQ_SAT)) ? gpfm_pkg::FREQ_SAT
                                                         : dq_reg[15:0];

    // ---------------- result ----------------
    always_comb begin
        res_push = 1'b0;
        res_data.freq_cent      = freq_hold_reg;
        res_data.cycle_boundary = 1'b0;
        res_data.zero_cross     = 1'b0;
        res_data.freq_update    = 1'b0;
        // period register is already updated by the time any result is pushed,
        // except for a take of a zero-period edge, handled here
        res_data.period_ticks   = 32'(period_reg);
        if (cmd.take && fall && primed_reg) begin
            res_data.period_ticks = 32'(tick_count_next);
        end
        if (cmd.div_done) begin
            res_push                = 1'b1;
            res_data.freq_cent      = range_ok ? freq_sat : 16'd0;
            res_data.cycle_boundary = range_ok;
            res_data.zero_cross     = range_ok;
            res_data.freq_update    = 1'b1;
        end else if (cmd.take && !status.eval_edge) begin
            res_push                = 1'b1;
            res_data.cycle_boundary = fall && !primed_reg;
        end
    end

endmodule

[src/gpfm_outbuf.sv]
`timescale 1ns / 1ps
// Output register with a skid entry so an item can be taken while a result
// is still waiting downstream. Depends on gpfm_pkg.
module gpfm_outbuf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  gpfm_pkg::result_t push_data,
    output logic              full,
    output logic              m_valid,
    input  logic              m_ready,
    output gpfm_pkg::result_t m_data
);

    logic              out_valid_reg;
    gpfm_pkg::result_t out_data_reg;
    logic              skid_valid_reg;
    gpfm_pkg::result_t skid_data_reg;
    logic              pop;

    assign pop     = out_valid_reg && m_ready;
    assign full    = skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || pop) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= push;
                end else begin
                    out_valid_reg <= push;
                end
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
                if (push) begin
                    skid_data_reg <= push_data;
                end
            end else if (push) begin
                out_data_reg <= push_data;
            end
        end else if (push) begin
            skid_data_reg <= push_data;
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Testbench for grid_period_frequency_meter: directed table, then random
// falling-edge trains under several register settings, checked item by item.
// Depends on gpfm_pkg and the grid_period_frequency_meter RTL.
module testbench;

    localparam int COUNT_W     = gpfm_pkg::COUNT_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic              lvl;
        bit                typed;
        gpfm_pkg::result_t want;
        logic [31:0]       clk_hz;
        logic [15:0]       lo_cent;
        logic [15:0]       hi_cent;
    } plan_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [gpfm_pkg::CFG_IDX_W-1:0]  cfg_addr;
    logic [gpfm_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic        s_signal_level;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_freq_cent;
    logic [31:0] m_period_ticks;
    logic        m_cycle_boundary;
    logic        m_zero_cross;
    logic        m_freq_update;

    // meter model state and its copy of the registers
    logic               lvl_prev;
    logic [COUNT_W-1:0] tick_cnt;
    logic               is_primed;
    logic [COUNT_W-1:0] period_hold;
    logic [15:0]        freq_hold;
    logic [31:0]        cfg_clock_hz;
    logic [15:0]        cfg_min_cent;
    logic [15:0]        cfg_max_cent;

    gpfm_pkg::result_t due_results[$];
    plan_row_t         plan[$];

    int  errors = 0;
    int  cycles = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  edges_evaluated = 0;
    int  edges_accepted = 0;
    int  settings_used = 1;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;

    grid_period_frequency_meter dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_signal_level   (s_signal_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_freq_cent      (m_freq_cent),
        .m_period_ticks   (m_period_ticks),
        .m_cycle_boundary (m_cycle_boundary),
        .m_zero_cross     (m_zero_cross),
        .m_freq_update    (m_freq_update)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // One sample of the signal through the meter; returns the result it yields.
    function automatic gpfm_pkg::result_t meter_step(input logic lvl);
        gpfm_pkg::result_t r;
        logic [63:0] period;
        logic [63:0] scaled;
        logic [63:0] quot;
        logic        accept;
        r = '0;
        tick_cnt = tick_cnt + 1'b1;
        if (lvl_prev && !lvl) begin
            period = 64'(tick_cnt);
            tick_cnt = '0;
            if (!is_primed) begin
                is_primed = 1'b1;
                r.cycle_boundary = 1'b1;
            end else begin
                period_hold = period[COUNT_W-1:0];
                if (period != 64'd0) begin
                    scaled = 64'(cfg_clock_hz) * 64'd100;
                    quot = scaled / period;
                    accept = (period * 64'(cfg_min_cent) <= scaled) &&
                             (scaled <= period * 64'(cfg_max_cent));
                    r.freq_update = 1'b1;
                    if (accept) begin
                        freq_hold = (quot > 64'hFFFF) ? gpfm_pkg::FREQ_SAT : quot[15:0];
                        r.cycle_boundary = 1'b1;
                        r.zero_cross = 1'b1;
                    end else begin
                        freq_hold = '0;
                    end
                end
            end
        end
        lvl_prev = lvl;
        r.freq_cent = freq_hold;
        r.period_ticks = period_hold[31:0];
        return r;
    endfunction

    function automatic plan_row_t row_item(input logic lvl);
        plan_row_t row;
        row = '{ROW_ITEM, lvl, 1'b0, '0, '0, '0, '0};
        return row;
    endfunction

    function automatic plan_row_t row_known(input logic lvl, input gpfm_pkg::result_t want);
        plan_row_t row;
        row = '{ROW_ITEM, lvl, 1'b1, want, '0, '0, '0};
        return row;
    endfunction

    function automatic plan_row_t row_cfg(input logic [31:0] clk_hz,
                                          input logic [15:0] lo_cent,
                                          input logic [15:0] hi_cent);
        plan_row_t row;
        row = '{ROW_CFG, 1'b0, 1'b0, '0, clk_hz, lo_cent, hi_cent};
        return row;
    endfunction

    task automatic send_item(input logic lvl, input bit typed, input gpfm_pkg::result_t want);
        gpfm_pkg::result_t pred;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_signal_level <= lvl;
        do @(posedge aclk); while (!s_ready);
        pred = meter_step(lvl);
        due_results.push_back(typed ? want : pred);
        items_sent++;
    endtask

    // Drain, then write all three registers on back-to-back cycles.
    task automatic configure(input logic [31:0] clk_hz, input logic [15:0] lo_cent,
                             input logic [15:0] hi_cent);
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= gpfm_pkg::REG_CLOCK_HZ;
        cfg_wdata <= clk_hz;
        @(posedge aclk);
        cfg_addr  <= gpfm_pkg::REG_MIN_CENT;
        cfg_wdata <= 32'(lo_cent);
        @(posedge aclk);
        cfg_addr  <= gpfm_pkg::REG_MAX_CENT;
        cfg_wdata <= 32'(hi_cent);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_clock_hz = clk_hz;
        cfg_min_cent = lo_cent;
        cfg_max_cent = hi_cent;
        settings_used++;
    endtask

    // Mostly clean square waves of random period and duty, some glitch bursts.
    task automatic run_phase(input int n_items, input int p_lo, input int p_hi);
        int sent;
        int p;
        int h;
        int len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 85) begin
                p = $urandom_range(p_lo, p_hi);
                h = $urandom_range(1, p - 1);
                for (int i = 0; i < p; i++) send_item(i < h, 1'b0, '0);
                sent += p;
            end else begin
                len = $urandom_range(1, 8);
                repeat (len) send_item(1'($urandom_range(0, 1)), 1'b0, '0);
                sent += len;
            end
        end
    endtask

    always @(posedge aclk) begin : result_check
        gpfm_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            edges_evaluated += m_freq_update;
            edges_accepted  += m_zero_cross;
            if (due_results.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
            end else begin
                want = due_results.pop_front();
                if (m_freq_cent !== want.freq_cent) begin
                    $error("freq_cent: expected %0d, got %0d", want.freq_cent, m_freq_cent);
                    errors++;
                end
                if (m_period_ticks !== want.period_ticks) begin
                    $error("period_ticks: expected %0d, got %0d",
                           want.period_ticks, m_period_ticks);
                    errors++;
                end
                if (m_cycle_boundary !== want.cycle_boundary) begin
                    $error("cycle_boundary: expected %0d, got %0d",
                           want.cycle_boundary, m_cycle_boundary);
                    errors++;
                end
                if (m_zero_cross !== want.zero_cross) begin
                    $error("zero_cross: expected %0d, got %0d", want.zero_cross, m_zero_cross);
                    errors++;
                end
                if (m_freq_update !== want.freq_update) begin
                    $error("freq_update: expected %0d, got %0d",
                           want.freq_update, m_freq_update);
                    errors++;
                end
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = gpfm_pkg::REG_CLOCK_HZ;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_signal_level = 1'b0;

        lvl_prev     = 1'b0;
        tick_cnt     = '0;
        is_primed    = 1'b0;
        period_hold  = '0;
        freq_hold    = '0;
        cfg_clock_hz = gpfm_pkg::CLOCK_HZ_RST;
        cfg_min_cent = gpfm_pkg::MIN_CENT_RST;
        cfg_max_cent = gpfm_pkg::MAX_CENT_RST;

        // fields: freq_cent, period_ticks, cycle_boundary, zero_cross, freq_update
        plan.push_back(row_known(1'b0, {16'd0, 32'd0, 1'b0, 1'b0, 1'b0}));
        plan.push_back(row_known(1'b1, {16'd0, 32'd0, 1'b0, 1'b0, 1'b0}));
        plan.push_back(row_known(1'b0, {16'd0, 32'd0, 1'b1, 1'b0, 1'b0})); // priming edge
        plan.push_back(row_known(1'b1, {16'd0, 32'd0, 1'b0, 1'b0, 1'b0}));
        plan.push_back(row_known(1'b0, {16'd0, 32'd2, 1'b0, 1'b0, 1'b1})); // far too fast
        // window collapsed to one value, hit exactly at period 2
        plan.push_back(row_cfg(32'd1, 16'd50, 16'd50));
        plan.push_back(row_known(1'b1, {16'd0, 32'd2, 1'b0, 1'b0, 1'b0}));
        plan.push_back(row_known(1'b0, {16'd50, 32'd2, 1'b1, 1'b1, 1'b1}));
        plan.push_back(row_item(1'b0));
        plan.push_back(row_item(1'b1));
        plan.push_back(row_known(1'b0, {16'd0, 32'd3, 1'b0, 1'b0, 1'b1}));
        // zero clock: frequency 0 passes only with a zero lower bound
        plan.push_back(row_cfg(32'd0, 16'd0, 16'd0));
        plan.push_back(row_item(1'b1));
        plan.push_back(row_known(1'b0, {16'd0, 32'd2, 1'b1, 1'b1, 1'b1}));
        // top clock: quotient overflows the 16-bit range and the edge is rejected
        plan.push_back(row_cfg(32'hFFFF_FFFF, 16'd0, 16'hFFFF));
        plan.push_back(row_item(1'b1));
        plan.push_back(row_known(1'b0, {16'd0, 32'd2, 1'b0, 1'b0, 1'b1}));
        // lower bound above upper bound rejects everything
        plan.push_back(row_cfg(32'd1, 16'd33, 16'd30));
        plan.push_back(row_item(1'b1));
        plan.push_back(row_item(1'b1));
        plan.push_back(row_item(1'b0));
        plan.push_back(row_cfg(32'd1, 16'd0, 16'hFFFF));
        plan.push_back(row_item(1'b1));
        plan.push_back(row_item(1'b1));
        plan.push_back(row_item(1'b1));
        plan.push_back(row_item(1'b0));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                configure(plan[i].clk_hz, plan[i].lo_cent, plan[i].hi_cent);
            else
                send_item(plan[i].lvl, plan[i].typed, plan[i].want);
        end

        // nominal window, 15..22 ticks accepted; output held off at the start
        configure(32'd1000, gpfm_pkg::MIN_CENT_RST, gpfm_pkg::MAX_CENT_RST);
        hold_req = 1'b1;
        run_phase(220, 10, 28);
        // period 20 lands exactly on the 16-bit frequency ceiling
        configure(32'd13107, 16'd0, 16'hFFFF);
        run_phase(220, 18, 44);
        configure(32'd1, 16'd0, 16'hFFFF);
        run_phase(160, 2, 9);
        configure(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        run_phase(100, 2, 12);
        repeat (2) begin
            configure($urandom_range(300, 3000), 16'($urandom_range(0, 9000)),
                      16'($urandom_range(0, 12000)));
            run_phase(120, 4, 40);
        end
        configure(32'd1000, gpfm_pkg::MIN_CENT_RST, gpfm_pkg::MAX_CENT_RST);
        quiet = 1'b1;
        run_phase(150, 12, 26);

        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("Sent %0d signal samples under %0d register settings, %0d results checked",
                 items_sent, settings_used, results_seen);
        $display("Evaluated edges: %0d, in-window cycles: %0d", edges_evaluated,
                 edges_accepted);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
src/gpfm_pkg.sv
src/gpfm_ctrl.sv
src/gpfm_dp.sv
src/gpfm_outbuf.sv
src/grid_period_frequency_meter.sv
sim/testbench.sv
